// ----- hw/rtl/tsps_pkg.sv -----
// ----------------------------------------------------------------------------
// tsps_pkg
// Shared widths, reciprocal table and controller/datapath command and status
// types for the sine partial sum block.
// ----------------------------------------------------------------------------
package tsps_pkg;

  localparam int ANGLE_W    = 32;
  localparam int TERM_IN_W  = 5;
  localparam int IDX_W      = 6;    // term index, holds up to 63
  localparam int TERM_W     = 62;   // term magnitude, capped at 2^62-1
  localparam int OP_W       = 64;   // multiplier operand width
  localparam int PROD_W     = 128;  // full product width
  localparam int RECIP_BITS = 40;
  localparam int SUM_W      = 37;   // running sum with overflow codes
  localparam int OUT_W      = 36;
  localparam int TAB_N      = 32;
  localparam int TAB_AW     = 5;

  localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_BITS;

  // R(k) = round(2^40 / (2k(2k+1))), entry 0 unused
  localparam logic [RECIP_BITS-1:0] RECIP_TAB [TAB_N] = '{
    40'd0,
    40'((RECIP_ONE + 64'd3)    / 64'd6),
    40'((RECIP_ONE + 64'd10)   / 64'd20),
    40'((RECIP_ONE + 64'd21)   / 64'd42),
    40'((RECIP_ONE + 64'd36)   / 64'd72),
    40'((RECIP_ONE + 64'd55)   / 64'd110),
    40'((RECIP_ONE + 64'd78)   / 64'd156),
    40'((RECIP_ONE + 64'd105)  / 64'd210),
    40'((RECIP_ONE + 64'd136)  / 64'd272),
    40'((RECIP_ONE + 64'd171)  / 64'd342),
    40'((RECIP_ONE + 64'd210)  / 64'd420),
    40'((RECIP_ONE + 64'd253)  / 64'd506),
    40'((RECIP_ONE + 64'd300)  / 64'd600),
    40'((RECIP_ONE + 64'd351)  / 64'd702),
    40'((RECIP_ONE + 64'd406)  / 64'd812),
    40'((RECIP_ONE + 64'd465)  / 64'd930),
    40'((RECIP_ONE + 64'd528)  / 64'd1056),
    40'((RECIP_ONE + 64'd595)  / 64'd1190),
    40'((RECIP_ONE + 64'd666)  / 64'd1332),
    40'((RECIP_ONE + 64'd741)  / 64'd1482),
    40'((RECIP_ONE + 64'd820)  / 64'd1640),
    40'((RECIP_ONE + 64'd903)  / 64'd1806),
    40'((RECIP_ONE + 64'd990)  / 64'd1980),
    40'((RECIP_ONE + 64'd1081) / 64'd2162),
    40'((RECIP_ONE + 64'd1176) / 64'd2352),
    40'((RECIP_ONE + 64'd1275) / 64'd2550),
    40'((RECIP_ONE + 64'd1378) / 64'd2756),
    40'((RECIP_ONE + 64'd1485) / 64'd2970),
    40'((RECIP_ONE + 64'd1596) / 64'd3192),
    40'((RECIP_ONE + 64'd1711) / 64'd3422),
    40'((RECIP_ONE + 64'd1830) / 64'd3660),
    40'((RECIP_ONE + 64'd1953) / 64'd3906)
  };

  typedef enum logic [1:0] {
    MUL_SQ,     // |x| * |x|
    MUL_T_SQ,   // t * x^2
    MUL_T_R     // t * R(i-1)
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     take_sq;
    logic     take_t;
    logic     acc_add;
    logic     i_inc;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic i_gt_last;
    logic i_ge_first;
    logic i_ge_two;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/tsps_mul.sv -----
// ----------------------------------------------------------------------------
// tsps_mul
// Iterative 64x64 multiplier on one 32x32 unit: four partial products,
// rounding, right shift by the fraction or reciprocal bits, cap at 2^62-1.
// ----------------------------------------------------------------------------
module tsps_mul #(
  parameter int FRAC_BITS = 28
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         recip_i,
  input  logic [tsps_pkg::OP_W-1:0]    a_i,
  input  logic [tsps_pkg::OP_W-1:0]    b_i,
  output logic                         done_o,
  output logic [tsps_pkg::TERM_W-1:0]  res_o
);

  localparam int HALF_W = tsps_pkg::OP_W / 2;
  localparam int PW     = tsps_pkg::PROD_W;
  localparam int TW     = tsps_pkg::TERM_W;
  localparam int RB     = tsps_pkg::RECIP_BITS;
  localparam logic [PW-1:0] RND_FRAC  = PW'(1) << (FRAC_BITS - 1);
  localparam logic [PW-1:0] RND_RECIP = PW'(1) << (RB - 1);

  logic [tsps_pkg::OP_W-1:0] a_q, b_q;
  logic                      recip_q;
  logic                      run_q;
  logic [1:0]                issue_q;
  logic                      pp_vld_q, pp_last_q, fin_q, done_q;
  logic [2*HALF_W-1:0]       pp_q;
  logic [1:0]                pos_q;
  logic [PW-1:0]             acc_q;
  logic [TW-1:0]             res_q;

  logic [HALF_W-1:0]   a_half, b_half;
  logic [2*HALF_W-1:0] pp_d;
  logic [PW-1:0]       pp_ext;
  logic [PW-1:0]       shifted;
  logic                ovf;
  logic [TW-1:0]       res_d;

  assign a_half = issue_q[0] ? a_q[2*HALF_W-1:HALF_W] : a_q[HALF_W-1:0];
  assign b_half = issue_q[1] ? b_q[2*HALF_W-1:HALF_W] : b_q[HALF_W-1:0];
  assign pp_d   = a_half * b_half;

  always_comb begin
    case (pos_q)
      2'd0:    pp_ext = {{(PW-2*HALF_W){1'b0}}, pp_q};
      2'd1:    pp_ext = {{(PW-3*HALF_W){1'b0}}, pp_q, {HALF_W{1'b0}}};
      2'd2:    pp_ext = {pp_q, {(2*HALF_W){1'b0}}};
      default: pp_ext = '0;
    endcase
  end

  // result at or above 2^62 saturates
  always_comb begin
    if (recip_q) begin
      shifted = acc_q >> RB;
      ovf     = |acc_q[PW-1:RB+TW];
    end else begin
      shifted = acc_q >> FRAC_BITS;
      ovf     = |acc_q[PW-1:FRAC_BITS+TW];
    end
    res_d = ovf ? {TW{1'b1}} : shifted[TW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      issue_q   <= 2'd0;
      pp_vld_q  <= 1'b0;
      pp_last_q <= 1'b0;
      fin_q     <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      pp_vld_q  <= run_q;
      pp_last_q <= run_q && (issue_q == 2'd3);
      fin_q     <= pp_vld_q && pp_last_q;
      done_q    <= fin_q;
      if (start_i) begin
        run_q   <= 1'b1;
        issue_q <= 2'd0;
      end else if (run_q) begin
        issue_q <= issue_q + 2'd1;
        if (issue_q == 2'd3) run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q     <= a_i;
      b_q     <= b_i;
      recip_q <= recip_i;
      acc_q   <= recip_i ? RND_RECIP : RND_FRAC;
    end else if (pp_vld_q) begin
      acc_q <= acc_q + pp_ext;
    end
    if (run_q) begin
      pp_q  <= pp_d;
      pos_q <= {1'b0, issue_q[0]} + {1'b0, issue_q[1]};
    end
    if (fin_q) res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !(run_q || pp_vld_q || fin_q))
    else $error("multiplier started while busy");
`endif

endmodule

// ----- hw/rtl/tsps_datapath.sv -----
// ----------------------------------------------------------------------------
// tsps_datapath
// Input capture, x^2 and term registers, term index, saturating sum and the
// output register. Runs on commands from the controller.
// ----------------------------------------------------------------------------
module tsps_datapath #(
  parameter int MAX_TERMS = 16,
  parameter int FRAC_BITS = 28
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [tsps_pkg::ANGLE_W-1:0] angle_i,
  input  logic [tsps_pkg::TERM_IN_W-1:0]      first_term_i,
  input  logic [tsps_pkg::TERM_IN_W-1:0]      last_term_i,
  input  tsps_pkg::cmd_t                      cmd_i,
  output tsps_pkg::sts_t                      sts_o,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic signed [tsps_pkg::OUT_W-1:0]   partial_sum_o
);

  localparam int AW  = tsps_pkg::ANGLE_W;
  localparam int IW  = tsps_pkg::IDX_W;
  localparam int TW  = tsps_pkg::TERM_W;
  localparam int OW  = tsps_pkg::OP_W;
  localparam int SW  = tsps_pkg::SUM_W;
  localparam int QW  = tsps_pkg::OUT_W;
  localparam logic [IW-1:0] MAX_IDX = IW'(MAX_TERMS);
  localparam logic signed [63:0] SUM_MAX = 64'sd34359738367;
  localparam logic signed [63:0] SUM_MIN = -64'sd34359738368;
  localparam logic signed [SW-1:0] ACC_HI = SW'(SUM_MAX + 64'sd1);
  localparam logic signed [SW-1:0] ACC_LO = SW'(SUM_MIN - 64'sd1);

  logic [AW-1:0]          mag_q;
  logic                   neg_q;
  logic [IW-1:0]          first_q, last_q, i_q;
  logic [TW-1:0]          sq_q, t_q;
  logic signed [SW-1:0]   acc_q;
  logic signed [QW-1:0]   out_q;
  logic                   out_vld_q;

  logic [AW-1:0]          mag_d;
  logic [IW-1:0]          first_ext, last_ext, km1;
  logic [OW-1:0]          mul_a, mul_b;
  logic                   mul_recip, mul_done;
  logic [TW-1:0]          mul_res;
  logic signed [63:0]     acc_ext, t_ext, sum;
  logic                   tneg;
  logic signed [SW-1:0]   acc_d;
  logic signed [QW-1:0]   out_d;
  logic                   out_free;

  assign mag_d     = angle_i[AW-1] ? (~angle_i + AW'(1)) : angle_i;
  assign first_ext = IW'(first_term_i);
  assign last_ext  = IW'(last_term_i);
  assign km1       = i_q - IW'(1);

  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_recip = 1'b0;
    case (cmd_i.mul_sel)
      tsps_pkg::MUL_SQ: begin
        mul_a = OW'(mag_q);
        mul_b = OW'(mag_q);
      end
      tsps_pkg::MUL_T_SQ: begin
        mul_a = OW'(t_q);
        mul_b = OW'(sq_q);
      end
      tsps_pkg::MUL_T_R: begin
        mul_a     = OW'(t_q);
        mul_b     = OW'(tsps_pkg::RECIP_TAB[km1[tsps_pkg::TAB_AW-1:0]]);
        mul_recip = 1'b1;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  tsps_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .recip_i (mul_recip),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // odd terms carry the angle's sign, even terms the opposite
  assign tneg    = neg_q ^ ~i_q[0];
  assign acc_ext = 64'(acc_q);
  assign t_ext   = $signed({2'b00, t_q});
  assign sum     = tneg ? (acc_ext - t_ext) : (acc_ext + t_ext);

  // a sum past the output range is parked one step outside it
  always_comb begin
    if (sum > SUM_MAX)      acc_d = ACC_HI;
    else if (sum < SUM_MIN) acc_d = ACC_LO;
    else                    acc_d = sum[SW-1:0];
  end

  always_comb begin
    if (acc_ext > SUM_MAX)      out_d = $signed(SUM_MAX[QW-1:0]);
    else if (acc_ext < SUM_MIN) out_d = $signed(SUM_MIN[QW-1:0]);
    else                        out_d = acc_ext[QW-1:0];
  end

  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mag_q   <= mag_d;
      neg_q   <= angle_i[AW-1];
      first_q <= (first_term_i == '0) ? IW'(1) : first_ext;
      last_q  <= (last_ext > MAX_IDX) ? MAX_IDX : last_ext;
      t_q     <= TW'(mag_d);
      i_q     <= IW'(1);
      acc_q   <= '0;
    end else begin
      if (cmd_i.take_sq) sq_q <= mul_res;
      if (cmd_i.take_t)  t_q  <= mul_res;
      if (cmd_i.acc_add) acc_q <= acc_d;
      if (cmd_i.i_inc)   i_q  <= i_q + IW'(1);
    end
    if (cmd_i.out_load) out_q <= out_d;
  end

  assign sts_o.mul_done   = mul_done;
  assign sts_o.i_gt_last  = i_q > last_q;
  assign sts_o.i_ge_first = i_q >= first_q;
  assign sts_o.i_ge_two   = i_q >= IW'(2);
  assign sts_o.out_free   = out_free;

  assign out_valid_o   = out_vld_q;
  assign partial_sum_o = out_q;

`ifndef SYNTHESIS
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("output word overwritten while held");

  a_recip_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mul_start && cmd_i.mul_sel == tsps_pkg::MUL_T_R) |->
      (i_q >= IW'(2) && i_q <= last_q))
    else $error("reciprocal fetched for an invalid term");
`endif

endmodule

// ----- hw/rtl/tsps_ctrl.sv -----
// ----------------------------------------------------------------------------
// tsps_ctrl
// Sequencer: accepts a word, forms x^2, then walks the terms up to the last
// index, two multiplications per term after the first, and hands the sum to the output.
// ----------------------------------------------------------------------------
module tsps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output tsps_pkg::cmd_t cmd_o,
  input  tsps_pkg::sts_t sts_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_GO,
    S_SQ_WAIT,
    S_CHECK,
    S_M1_GO,
    S_M1_WAIT,
    S_M2_GO,
    S_M2_WAIT,
    S_ADD,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = tsps_pkg::MUL_SQ;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_SQ_GO;
        end
      end
      S_SQ_GO: begin
        cmd_o.mul_start = 1'b1;
        state_d = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.take_sq = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.i_gt_last)     state_d = S_FINISH;
        else if (sts_i.i_ge_two) state_d = S_M1_GO;
        else                     state_d = S_ADD;
      end
      S_M1_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = tsps_pkg::MUL_T_SQ;
        state_d = S_M1_WAIT;
      end
      S_M1_WAIT: begin
        cmd_o.mul_sel = tsps_pkg::MUL_T_SQ;
        if (sts_i.mul_done) begin
          cmd_o.take_t = 1'b1;
          state_d = S_M2_GO;
        end
      end
      S_M2_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = tsps_pkg::MUL_T_R;
        state_d = S_M2_WAIT;
      end
      S_M2_WAIT: begin
        cmd_o.mul_sel = tsps_pkg::MUL_T_R;
        if (sts_i.mul_done) begin
          cmd_o.take_t = 1'b1;
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.acc_add = sts_i.i_ge_first;
        cmd_o.i_inc   = 1'b1;
        state_d = S_CHECK;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

`ifndef SYNTHESIS
  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |->
      (state_q == S_SQ_WAIT || state_q == S_M1_WAIT || state_q == S_M2_WAIT))
    else $error("multiplier result arrived with nobody waiting");

  a_add_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD) |-> !sts_i.i_gt_last)
    else $error("term added beyond the last index");
`endif

endmodule

// ----- hw/rtl/taylor_sine_partial_sum.sv -----
// ----------------------------------------------------------------------------
// taylor_sine_partial_sum
// Partial Maclaurin sum of sin(x) over a range of term indices.
// Input word: angle_i (signed Q3.28 radians), first_term_i, last_term_i,
// taken when in_valid_i is high and in_stall_o is low. Output word:
// partial_sum_o (signed Q7.28, saturated), taken when out_valid_o is high
// and out_stall_i is low. One output word per input word, in order.
// Words are worked on one at a time. x^2 and each term after the first are
// formed on one shared 32x32 multiplier, four partial products plus rounding
// per 64-bit product. The next word is taken once the sum is loaded into
// the output register. in_stall_o stays high while a word is being worked
// on. A finished word waits in the output register while the receiver
// stalls; the block then holds the next sum until that one is taken.
// Reset clears the sequencer and the output valid; no state is kept
// between words.
// ----------------------------------------------------------------------------
module taylor_sine_partial_sum #(
  parameter int MAX_TERMS = 16,
  parameter int FRAC_BITS = 28
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tsps_pkg::ANGLE_W-1:0] angle_i,
  input  logic [tsps_pkg::TERM_IN_W-1:0]      first_term_i,
  input  logic [tsps_pkg::TERM_IN_W-1:0]      last_term_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tsps_pkg::OUT_W-1:0]   partial_sum_o
);

  tsps_pkg::cmd_t cmd;
  tsps_pkg::sts_t sts;

  tsps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  tsps_datapath #(
    .MAX_TERMS (MAX_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .angle_i       (angle_i),
    .first_term_i  (first_term_i),
    .last_term_i   (last_term_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .partial_sum_o (partial_sum_o)
  );

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for taylor_sine_partial_sum. Angle and term range
// words are fed through the valid/stall input from a queue of pending words,
// and each accepted word is run through a bit-exact fixed point model of the
// partial sine sum. Output words are compared in order with the predicted
// sums. Both sides idle at random; the receiver also holds off for long
// stretches so that the block backs up onto its input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_W    = tsps_pkg::ANGLE_W;
  localparam int TERM_IN_W  = tsps_pkg::TERM_IN_W;
  localparam int OUT_W      = tsps_pkg::OUT_W;
  localparam int RECIP_BITS = tsps_pkg::RECIP_BITS;

  localparam int MAX_TERMS = 16;
  localparam int FRAC_BITS = 28;

  localparam int RANDOM_WORDS = 1800;
  localparam int DRAIN_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLD_CYCLES = 600;
  localparam int HOLD_MARK_A = 150;
  localparam int HOLD_MARK_B = 1200;

  localparam int ANGLE_LIMIT = 1686629713;  // 2*pi in Q3.28
  localparam int PI_Q = 843314857;
  localparam int HALF_PI_Q = 421657428;

  localparam logic [63:0] TERM_CAP = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MAX = 64'sd34359738367;
  localparam longint SUM_MIN = -64'sd34359738368;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic [TERM_IN_W-1:0]      first_term;
    logic [TERM_IN_W-1:0]      last_term;
  } sine_word_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic signed [ANGLE_W-1:0]   angle_i = '0;
  logic [TERM_IN_W-1:0]        first_term_i = '0;
  logic [TERM_IN_W-1:0]        last_term_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [OUT_W-1:0]     partial_sum_o;

  sine_word_t              pending_words[$];
  logic signed [OUT_W-1:0] expected_sums[$];
  sine_word_t              next_word;
  int                      errors = 0;
  int                      sums_seen = 0;
  int                      send_gap = 0;
  int                      stall_left = 0;
  bit                      send_calm = 1'b0;
  bit                      recv_calm = 1'b0;
  bit                      hold_off = 1'b0;
  int                      hold_cnt = 0;
  int                      hold_mark = HOLD_MARK_A;
  int                      idle_cycles = 0;

  taylor_sine_partial_sum #(
    .MAX_TERMS(MAX_TERMS),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .angle_i      (angle_i),
    .first_term_i (first_term_i),
    .last_term_i  (last_term_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .partial_sum_o(partial_sum_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // (a*b + half) >> shift on a full-width product, capped at the term limit
  function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b,
                                                 int unsigned shift);
    logic [128:0] wide;
    wide = {65'd0, a} * {65'd0, b};
    wide = (wide + (129'd1 << (shift - 1))) >> shift;
    return (wide > {65'd0, TERM_CAP}) ? TERM_CAP : wide[63:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] sine_partial_sum_of(
      logic signed [ANGLE_W-1:0] angle, logic [TERM_IN_W-1:0] first_term,
      logic [TERM_IN_W-1:0] last_term);
    logic [ANGLE_W-1:0] raw;
    logic [ANGLE_W-1:0] absval;
    logic               neg;
    logic               term_neg;
    logic [63:0]        mag;
    logic [63:0]        sq;
    logic [63:0]        term;
    logic [63:0]        div;
    logic [63:0]        recip;
    int unsigned        lo;
    int unsigned        hi;
    int unsigned        i;
    longint             acc;
    logic [63:0]        acc_bits;
    raw = angle;
    neg = raw[ANGLE_W-1];
    absval = neg ? -raw : raw;
    mag = {32'd0, absval};
    lo = (first_term == 0) ? 1 : first_term;
    hi = (last_term > MAX_TERMS) ? MAX_TERMS : last_term;
    sq = scaled_product(mag, mag, FRAC_BITS);
    term = mag;
    acc = 0;
    for (i = 1; i <= hi; i++) begin
      if (i >= 2) begin
        div = 64'(2 * (i - 1)) * 64'(2 * (i - 1) + 1);
        recip = ((64'd1 << RECIP_BITS) + div / 2) / div;
        term = scaled_product(term, sq, FRAC_BITS);
        term = scaled_product(term, recip, RECIP_BITS);
      end
      if (i >= lo) begin
        term_neg = neg ^ (i % 2 == 0);
        if (term_neg) acc = acc - longint'(term);
        else acc = acc + longint'(term);
        // on overflow, park just outside the range
        if (acc > SUM_MAX) acc = SUM_MAX + 1;
        if (acc < SUM_MIN) acc = SUM_MIN - 1;
      end
    end
    if (acc > SUM_MAX) acc = SUM_MAX;
    if (acc < SUM_MIN) acc = SUM_MIN;
    acc_bits = acc;
    return acc_bits[OUT_W-1:0];
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_length(bit calm);
    int pick;
    pick = $urandom_range(0, 99);
    if (calm) return 0;
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] want,
                                 input logic [OUT_W-1:0] got);
    errors++;
    $display("mismatch at result %0d: %s, expected %h, got %h", sums_seen, what,
             want, got);
  endtask

  task automatic add_word(input logic signed [ANGLE_W-1:0] angle,
                          input logic [TERM_IN_W-1:0] first_term,
                          input logic [TERM_IN_W-1:0] last_term);
    sine_word_t w;
    w.angle = angle;
    w.first_term = first_term;
    w.last_term = last_term;
    pending_words.push_back(w);
  endtask

  task automatic add_random_word();
    logic signed [ANGLE_W-1:0] angle;
    logic [TERM_IN_W-1:0]      first_term;
    logic [TERM_IN_W-1:0]      last_term;
    if ($urandom_range(0, 9) == 0) angle = $urandom;
    else angle = $urandom_range(0, 2 * ANGLE_LIMIT) - ANGLE_LIMIT;
    if ($urandom_range(0, 99) < 85) first_term = TERM_IN_W'($urandom_range(1, 6));
    else first_term = TERM_IN_W'($urandom_range(0, 31));
    if ($urandom_range(0, 99) < 85) last_term = TERM_IN_W'($urandom_range(0, MAX_TERMS));
    else last_term = TERM_IN_W'($urandom_range(0, 31));
    add_word(angle, first_term, last_term);
  endtask

  // driver: a new word goes out once the current one is taken or none is up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
      send_calm <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) send_calm <= ~send_calm;
      if (in_valid_i && !in_stall_o)
        expected_sums.push_back(sine_partial_sum_of(angle_i, first_term_i, last_term_i));
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          in_valid_i <= 1'b1;
          angle_i <= next_word.angle;
          first_term_i <= next_word.first_term;
          last_term_i <= next_word.last_term;
          send_gap <= idle_length(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-offs so the block backs up onto its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off <= 1'b0;
      hold_cnt <= 0;
      hold_mark <= HOLD_MARK_A;
    end else if (hold_off) begin
      if (hold_cnt <= 1) hold_off <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (sums_seen == hold_mark) begin
      hold_off <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      hold_mark <= (hold_mark == HOLD_MARK_A) ? HOLD_MARK_B : -1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
      recv_calm <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) recv_calm <= ~recv_calm;
      out_stall_i <= hold_off || (stall_left != 0);
      if (stall_left != 0) stall_left <= stall_left - 1;
      else if ($urandom_range(0, 7) == 0) stall_left <= idle_length(recv_calm);
    end
  end

  // monitor: each taken word is checked against the oldest predicted sum
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_sums.size() == 0) begin
        report_mismatch("result with nothing expected", '0, partial_sum_o);
      end else if (partial_sum_o !== expected_sums[0]) begin
        report_mismatch("partial_sum", expected_sums[0], partial_sum_o);
        void'(expected_sums.pop_front());
      end else begin
        void'(expected_sums.pop_front());
      end
      sums_seen <= sums_seen + 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[taylor_sine_partial_sum] ERROR");
        $finish;
      end
    end
  end

  initial begin
    // zero angle, angle limits and out-of-range patterns
    add_word(0, 1, MAX_TERMS);
    add_word(ANGLE_LIMIT, 1, MAX_TERMS);
    add_word(-ANGLE_LIMIT, 1, MAX_TERMS);
    add_word(32'sh7FFF_FFFF, 1, MAX_TERMS);
    add_word(32'sh8000_0000, 1, MAX_TERMS);
    add_word(32'sh8000_0001, 1, 31);
    add_word(1, 1, 1);
    add_word(-1, 1, 2);
    add_word(HALF_PI_Q, 1, MAX_TERMS);
    add_word(-HALF_PI_Q, 1, 8);
    add_word(PI_Q, 2, 9);
    // empty ranges
    add_word(PI_Q, 1, 0);
    add_word(PI_Q, 5, 4);
    add_word(-PI_Q, 31, 16);
    add_word(-PI_Q, 31, 31);
    // first index zero behaves as one
    add_word(HALF_PI_Q, 0, 5);
    add_word(-ANGLE_LIMIT, 0, 0);
    // last index past the term count, and single-term ranges
    add_word(ANGLE_LIMIT, 3, 31);
    add_word(-ANGLE_LIMIT, 16, 17);
    add_word(PI_Q, MAX_TERMS, MAX_TERMS);
    add_word(32'sh4000_0000, 2, 2);
    add_word(32'shC000_0000, 1, 24);
    for (int n = 0; n < RANDOM_WORDS; n++) add_random_word();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_words.size() != 0 || in_valid_i || expected_sums.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("[taylor_sine_partial_sum] OK");
    end else begin
      $display("[taylor_sine_partial_sum] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/tsps_pkg.sv
hw/rtl/tsps_mul.sv
hw/rtl/tsps_datapath.sv
hw/rtl/tsps_ctrl.sv
hw/rtl/taylor_sine_partial_sum.sv
sim/tb.sv
